// ===== rtl/perspective_point_projection_defines.svh =====
// Assertion macros shared by the perspective projection RTL.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PERSPECTIVE_POINT_PROJECTION_DEFINES_SVH
`define PERSPECTIVE_POINT_PROJECTION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PPP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ppp_pkg.sv =====
// Shared widths, register codes and side-band type for the projection block.
// No dependencies; imported by ppp_div_pipe and perspective_point_projection.
`default_nettype none

package ppp_pkg;

    localparam int COORD_W    = 32;
    localparam int COEF_W     = 16;
    localparam int SLOT_W     = 16;
    localparam int COORD_FRAC = 16;
    localparam int COEF_FRAC  = COEF_W - 4;
    localparam int PROD_W     = COORD_W + COEF_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int MAG_W      = ACC_W - 1;
    localparam int ZQ_W       = MAG_W - COEF_FRAC;
    localparam int Q_W        = COORD_W;
    localparam int DIV_STEPS  = Q_W;
    localparam int OUTM_W     = ZQ_W + 1;
    localparam int LANES      = 3;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 64;

    localparam logic [COORD_W-1:0] OUT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] OUT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REG_ROW0 = 2'd0,
        REG_ROW1 = 2'd1,
        REG_ROW2 = 2'd2,
        REG_WOFS = 2'd3
    } ppp_reg_t;

    // Per-item information that rides alongside the divider.
    typedef struct packed {
        logic [LANES-1:0]           xn;
        logic                       wn;
        logic                       wzero;
        logic [LANES-1:0]           ovf;
        logic [LANES-1:0][ZQ_W-1:0] zq;
    } ppp_side_t;

endpackage

`default_nettype wire

// ===== rtl/perspective_point_projection.sv =====
// Perspective projection of one Q16.16 point per item by a 3x4 Q4.12 matrix plus m33.
// Input channel in_valid/in_ready carries in_x, in_y, in_z; output channel
// out_valid/out_ready carries out_x, out_y, out_z, w_was_zero and saturated.
// Coefficients are written over the APB port (row0..row2 at 0x00/0x08/0x10,
// w_offset at 0x18); write them only while no item is in flight.
// Throughput: one item per cycle while out_ready does not stall the pipeline. The result is
// registered through the input register, multiply, sum, sign/magnitude, 32 stages
// of the divider (one quotient bit per stage) and the output register.
// The whole pipeline advances together; when out_ready is low with a result
// waiting, every stage holds and in_ready drops, so nothing is lost or repeated.
// Reset clears all valid bits and loads the identity matrix with w offset 1.0,
// so points pass through unchanged until the registers are written.
// Depends on ppp_pkg, ppp_div_pipe and perspective_point_projection_defines.svh.
`default_nettype none

`include "perspective_point_projection_defines.svh"

module perspective_point_projection
    import ppp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] in_x,
    input  logic signed [COORD_W-1:0] in_y,
    input  logic signed [COORD_W-1:0] in_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic signed [COORD_W-1:0] out_z,
    output logic                      w_was_zero,
    output logic                      saturated
);

    // configuration
    logic [DATA_W-1:0] row_reg [LANES];
    logic [SLOT_W-1:0] wofs_reg;
    ppp_reg_t          reg_sel;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = ppp_reg_t'(paddr[ADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        case (reg_sel)
            REG_ROW0: prdata = row_reg[0];
            REG_ROW1: prdata = row_reg[1];
            REG_ROW2: prdata = row_reg[2];
            REG_WOFS: prdata = DATA_W'(wofs_reg);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= DATA_W'(64'h0000_0000_0000_1000);
            row_reg[1] <= DATA_W'(64'h0000_0000_1000_0000);
            row_reg[2] <= DATA_W'(64'h0000_1000_0000_0000);
            wofs_reg   <= SLOT_W'(16'h1000);
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_ROW0: row_reg[0] <= pwdata;
                REG_ROW1: row_reg[1] <= pwdata;
                REG_ROW2: row_reg[2] <= pwdata;
                REG_WOFS: wofs_reg   <= pwdata[SLOT_W-1:0];
                default:  ;
            endcase
        end
    end

    // pipeline control
    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // stage 1: input register
    logic               v1_reg;
    logic [COORD_W-1:0] xyz1_reg [LANES];
    logic [COORD_W-1:0] xyz1_next[LANES];

    assign xyz1_next[0] = in_x;
    assign xyz1_next[1] = in_y;
    assign xyz1_next[2] = in_z;

    // stage 2: products, index row*4+col; col 3 is row's w coefficient times coord[row]
    localparam int NPROD = LANES * 4;
    logic                     v2_reg;
    logic signed [PROD_W-1:0] prod2_reg [NPROD];
    logic signed [PROD_W-1:0] prod2_next[NPROD];

    always_comb
    begin
        logic signed [COEF_W-1:0]  cf;
        logic signed [COORD_W-1:0] cv;
        for (int r = 0; r < LANES; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                cf = $signed(row_reg[r][SLOT_W*c +: COEF_W]);
                cv = $signed(xyz1_reg[(c == 3) ? r : c]);
                prod2_next[r*4 + c] = cv * cf;
            end
        end
    end

    // stage 3: sums; entry LANES is w
    logic                    v3_reg;
    logic signed [ACC_W-1:0] acc3_reg [LANES+1];
    logic signed [ACC_W-1:0] acc3_next[LANES+1];

    always_comb
    begin
        logic signed [ACC_W-1:0] wofs;
        wofs = ACC_W'($signed(wofs_reg[COEF_W-1:0]));
        for (int r = 0; r < LANES; r++)
        begin
            acc3_next[r] = ACC_W'(prod2_reg[r*4]) + ACC_W'(prod2_reg[r*4 + 1])
                         + ACC_W'(prod2_reg[r*4 + 2]);
        end
        acc3_next[LANES] = ACC_W'(prod2_reg[3]) + ACC_W'(prod2_reg[7])
                         + ACC_W'(prod2_reg[11]) + (wofs <<< COORD_FRAC);
    end

    // stage 4: sign/magnitude, overflow screen, divider seed
    logic             v4_reg;
    ppp_side_t        side4_reg, side4_next;
    logic [MAG_W-1:0] d4_reg, d4_next;
    logic [MAG_W-1:0] rem4_reg [LANES];
    logic [MAG_W-1:0] rem4_next[LANES];
    logic [Q_W-1:0]   lo4_reg  [LANES];
    logic [Q_W-1:0]   lo4_next [LANES];

    always_comb
    begin
        logic [ACC_W-1:0] neg_acc;
        logic [MAG_W-1:0] nm;
        neg_acc          = -acc3_reg[LANES];
        side4_next.wn    = acc3_reg[LANES][ACC_W-1];
        d4_next          = side4_next.wn ? neg_acc[MAG_W-1:0] : acc3_reg[LANES][MAG_W-1:0];
        side4_next.wzero = (d4_next == '0);
        for (int l = 0; l < LANES; l++)
        begin
            neg_acc            = -acc3_reg[l];
            side4_next.xn[l]   = acc3_reg[l][ACC_W-1];
            nm                 = side4_next.xn[l] ? neg_acc[MAG_W-1:0] : acc3_reg[l][MAG_W-1:0];
            side4_next.zq[l]   = nm[MAG_W-1:COEF_FRAC];
            rem4_next[l]       = MAG_W'(nm >> COORD_FRAC);
            lo4_next[l]        = {nm[COORD_FRAC-1:0], {(Q_W-COORD_FRAC){1'b0}}};
            // integer part of the quotient would not fit
            side4_next.ovf[l]  = (rem4_next[l] >= d4_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xyz1_reg  <= xyz1_next;
            prod2_reg <= prod2_next;
            acc3_reg  <= acc3_next;
            side4_reg <= side4_next;
            d4_reg    <= d4_next;
            rem4_reg  <= rem4_next;
            lo4_reg   <= lo4_next;
        end
    end

    // divider
    logic           vd;
    ppp_side_t      sided;
    logic [Q_W-1:0] qd [LANES];

    ppp_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v4_reg),
        .in_side   (side4_reg),
        .in_d      (d4_reg),
        .in_rem    (rem4_reg),
        .in_lo     (lo4_reg),
        .out_valid (vd),
        .out_side  (sided),
        .out_q     (qd)
    );

    // output stage: pick quotient, apply sign, clamp
    logic [COORD_W-1:0] res_reg [LANES];
    logic [COORD_W-1:0] res_next[LANES];
    logic               wz_reg, sat_reg, sat_next;

    always_comb
    begin
        logic [OUTM_W-1:0] m;
        logic              neg;
        logic [OUTM_W-1:0] lim;
        lim      = OUTM_W'(1) << (COORD_W - 1);
        sat_next = 1'b0;
        for (int l = 0; l < LANES; l++)
        begin
            if (sided.wzero)
            begin
                m = OUTM_W'(sided.zq[l]);
            end
            else if (sided.ovf[l])
            begin
                m = OUTM_W'(1) << Q_W;
            end
            else
            begin
                m = OUTM_W'(qd[l]);
            end
            neg = (sided.wzero ? sided.xn[l] : (sided.xn[l] ^ sided.wn)) && (m != '0);
            if (neg)
            begin
                if (m > lim)
                begin
                    res_next[l] = OUT_MIN;
                    sat_next    = 1'b1;
                end
                else
                begin
                    res_next[l] = -m[COORD_W-1:0];
                end
            end
            else if (m > lim - OUTM_W'(1))
            begin
                res_next[l] = OUT_MAX;
                sat_next    = 1'b1;
            end
            else
            begin
                res_next[l] = m[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
            wz_reg  <= sided.wzero;
            sat_reg <= sat_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_x      = $signed(res_reg[0]);
    assign out_y      = $signed(res_reg[1]);
    assign out_z      = $signed(res_reg[2]);
    assign w_was_zero = wz_reg;
    assign saturated  = sat_reg;

    // checks
    `PPP_ASSERT_IMP(a_seed_below_divisor,
        v4_reg && !side4_reg.wzero && !side4_reg.ovf[0], rem4_reg[0] < d4_reg,
        "divider seed not below divisor")

    `PPP_ASSERT_IMP(a_sat_at_limit, out_valid && saturated,
        res_reg[0] == OUT_MAX || res_reg[0] == OUT_MIN || res_reg[1] == OUT_MAX
        || res_reg[1] == OUT_MIN || res_reg[2] == OUT_MAX || res_reg[2] == OUT_MIN,
        "saturated flag without a clamped coordinate")

    `PPP_ASSERT_NXT(a_stall_holds_seed, !in_ready, $stable(v4_reg) && $stable(d4_reg),
        "pipeline moved while stalled")

endmodule

`default_nettype wire

// ===== rtl/ppp_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, three lanes sharing w.
// Depends on ppp_pkg.
`default_nettype none

module ppp_div_pipe
    import ppp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  ppp_side_t        in_side,
    input  logic [MAG_W-1:0] in_d,
    input  logic [MAG_W-1:0] in_rem [LANES],
    input  logic [Q_W-1:0]   in_lo  [LANES],
    output logic             out_valid,
    output ppp_side_t        out_side,
    output logic [Q_W-1:0]   out_q  [LANES]
);

    logic [DIV_STEPS-1:0] valid_reg, valid_next;
    ppp_side_t            side_reg [DIV_STEPS];
    ppp_side_t            side_next[DIV_STEPS];
    logic [MAG_W-1:0]     d_reg    [DIV_STEPS];
    logic [MAG_W-1:0]     d_next   [DIV_STEPS];
    logic [MAG_W-1:0]     rem_reg  [DIV_STEPS][LANES];
    logic [MAG_W-1:0]     rem_next [DIV_STEPS][LANES];
    logic [Q_W-1:0]       lo_reg   [DIV_STEPS][LANES];
    logic [Q_W-1:0]       lo_next  [DIV_STEPS][LANES];

    always_comb
    begin
        logic [MAG_W:0]   t;
        logic [MAG_W-1:0] rs;
        logic [Q_W-1:0]   ls;
        logic [MAG_W-1:0] ds;
        logic             ge;
        valid_next = {valid_reg[DIV_STEPS-2:0], in_valid};
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            ds = (s == 0) ? in_d : d_reg[(s == 0) ? 0 : s - 1];
            d_next[s]    = ds;
            side_next[s] = (s == 0) ? in_side : side_reg[(s == 0) ? 0 : s - 1];
            for (int l = 0; l < LANES; l++)
            begin
                rs = (s == 0) ? in_rem[l] : rem_reg[(s == 0) ? 0 : s - 1][l];
                ls = (s == 0) ? in_lo[l]  : lo_reg[(s == 0) ? 0 : s - 1][l];
                // shift in the next dividend bit, subtract when it fits
                t  = {rs, ls[Q_W-1]};
                ge = (t >= {1'b0, ds});
                rem_next[s][l] = ge ? MAG_W'(t - {1'b0, ds}) : t[MAG_W-1:0];
                lo_next[s][l]  = {ls[Q_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg <= side_next;
            d_reg    <= d_next;
            rem_reg  <= rem_next;
            lo_reg   <= lo_next;
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];
    assign out_q     = lo_reg[DIV_STEPS-1];

endmodule

`default_nettype wire
